>>> hw/rtl/imhtq_pkg.sv
`default_nettype none
package imhtq_pkg;

    localparam int TID_W      = 10;
    localparam int TIME_W     = 32;
    localparam int TOUT_W     = 31;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;
    localparam int MAX_RESULTS = 64;
    localparam int KW         = $clog2(MAX_RESULTS + 1);

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADJUST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [TID_W-1:0]  owner;
    } heap_entry_t;

    // wrap-aware ordering: a lies before b when a-b is negative
    function automatic logic before_f(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/indexed_min_heap_timer_queue.sv
// channel | direction | handshake            | words
// in      | sink      | in_valid / in_ready  | cmd, timer_id, timeout_ms, now_ms
// out     | source    | out_valid / out_ready| expired_valid, expired_id, queue_empty,
//         |           |                      | next_wait_ms, status, last
// one command at a time; each heap level of a sift takes up to two child reads, a compare
// and a write back, on the heap memory's separate read and write ports
// a tick repeats the root removal once for each fired timer
// clear walks the live slots, reading each one to clear its id table entry
// after reset the id table is swept with in_ready low
// a stalled output word holds the sequencer only when a new word is due
`default_nettype none
module indexed_min_heap_timer_queue #(
    parameter int HEAP_SLOTS = 64,
    parameter int ID_RANGE   = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [imhtq_pkg::CMD_W-1:0]   cmd,
    input  wire logic [imhtq_pkg::TID_W-1:0]   timer_id,
    input  wire logic [imhtq_pkg::TOUT_W-1:0]  timeout_ms,
    input  wire logic [imhtq_pkg::TIME_W-1:0]  now_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               expired_valid,
    output logic [imhtq_pkg::TID_W-1:0]        expired_id,
    output logic                               queue_empty,
    output logic [imhtq_pkg::TOUT_W-1:0]       next_wait_ms,
    output logic [imhtq_pkg::STAT_W-1:0]       status,
    output logic                               last
);
    import imhtq_pkg::*;

    localparam int SLOT_W = $clog2(HEAP_SLOTS);
    localparam int CNT_W  = $clog2(HEAP_SLOTS + 1);
    localparam int ID_W   = $clog2(ID_RANGE);
    localparam int IDE_W  = (ID_W > TID_W) ? ID_W : TID_W;
    localparam int CH_W   = SLOT_W + 2;
    localparam int IE_W   = SLOT_W + 1;

    typedef enum logic [18:0] {
        S_SWEEP    = 19'h00001,
        S_IDLE     = 19'h00002,
        S_IDCHK    = 19'h00004,
        S_SD_START = 19'h00008,
        S_SD_R1    = 19'h00010,
        S_SD_R2    = 19'h00020,
        S_SD_CMP   = 19'h00040,
        S_SU_START = 19'h00080,
        S_SU_CMP   = 19'h00100,
        S_PLACE    = 19'h00200,
        S_RM_START = 19'h00400,
        S_RM_ROOT  = 19'h00800,
        S_RM_LAST  = 19'h01000,
        S_TK_RD    = 19'h02000,
        S_TK_CHK   = 19'h04000,
        S_CL_RD    = 19'h08000,
        S_CL_W     = 19'h10000,
        S_FIN      = 19'h20000,
        S_FIN_W    = 19'h40000
    } state_t;

    function automatic logic [ID_W-1:0] id_idx(input logic [TID_W-1:0] v);
        logic [IDE_W-1:0] x;
        x = IDE_W'(v);
        return x[ID_W-1:0];
    endfunction

    // memories
    heap_entry_t      heap_mem [HEAP_SLOTS];
    logic [IE_W-1:0]  id_mem   [ID_RANGE];
    heap_entry_t      hrd_q;
    logic [IE_W-1:0]  ird_q;

    logic             hw_en, hr_en, iw_en, ir_en;
    logic [SLOT_W-1:0] hw_addr, hr_addr;
    heap_entry_t      hw_data;
    logic [ID_W-1:0]  iw_addr, ir_addr;
    logic [IE_W-1:0]  iw_data;

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_mem[hw_addr] <= hw_data;
        end
        if (hr_en)
        begin
            hrd_q <= heap_mem[hr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (iw_en)
        begin
            id_mem[iw_addr] <= iw_data;
        end
        if (ir_en)
        begin
            ird_q <= id_mem[ir_addr];
        end
    end

    // control and datapath registers
    state_t             state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [TID_W-1:0]   id_reg, id_next;
    logic [TIME_W-1:0]  exp_reg, exp_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [SLOT_W-1:0]  child_reg, child_next;
    heap_entry_t        e_reg, e_next;
    heap_entry_t        left_reg, left_next;
    heap_entry_t        ch_reg, ch_next;
    logic [SLOT_W-1:0]  ch_idx_reg, ch_idx_next;
    logic               moved_reg, moved_next;
    logic               up_ok_reg, up_ok_next;
    logic               tick_reg, tick_next;
    logic [KW-1:0]      k_reg, k_next;
    logic               pend_reg, pend_next;
    logic [TID_W-1:0]   pend_id_reg, pend_id_next;
    logic [ID_W-1:0]    sw_reg, sw_next;
    logic [SLOT_W-1:0]  clr_reg, clr_next;

    logic               ov_reg, ov_next;
    logic               o_exp_reg, o_exp_next;
    logic [TID_W-1:0]   o_id_reg, o_id_next;
    logic               o_empty_reg, o_empty_next;
    logic [TOUT_W-1:0]  o_wait_reg, o_wait_next;
    logic [STAT_W-1:0]  o_stat_reg, o_stat_next;
    logic               o_last_reg, o_last_next;

    logic               out_free;
    logic [CH_W-1:0]    c_w, c1_w;
    logic [TIME_W-1:0]  d_root;
    logic               root_fires;
    logic [TOUT_W-1:0]  wait_val;
    logic               id_ok;

    assign out_free   = !ov_reg || out_ready;
    assign c_w        = CH_W'({cur_reg, 1'b0}) + CH_W'(1);
    assign c1_w       = CH_W'(child_reg) + CH_W'(1);
    assign d_root     = hrd_q.expiry - now_reg;
    assign root_fires = (count_reg != '0) && (k_reg < KW'(MAX_RESULTS))
                        && ((d_root == '0) || d_root[TIME_W-1]);
    assign wait_val   = ((count_reg == '0) || d_root[TIME_W-1]) ? '0 : d_root[TOUT_W-1:0];
    assign id_ok      = 32'(timer_id) < 32'(ID_RANGE);

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ov_reg;
    assign expired_valid = o_exp_reg;
    assign expired_id    = o_id_reg;
    assign queue_empty   = o_empty_reg;
    assign next_wait_ms  = o_wait_reg;
    assign status        = o_stat_reg;
    assign last          = o_last_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        exp_next     = exp_reg;
        now_next     = now_reg;
        stat_next    = stat_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        child_next   = child_reg;
        e_next       = e_reg;
        left_next    = left_reg;
        ch_next      = ch_reg;
        ch_idx_next  = ch_idx_reg;
        moved_next   = moved_reg;
        up_ok_next   = up_ok_reg;
        tick_next    = tick_reg;
        k_next       = k_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        sw_next      = sw_reg;
        clr_next     = clr_reg;
        ov_next      = ov_reg && !out_ready;
        o_exp_next   = o_exp_reg;
        o_id_next    = o_id_reg;
        o_empty_next = o_empty_reg;
        o_wait_next  = o_wait_reg;
        o_stat_next  = o_stat_reg;
        o_last_next  = o_last_reg;

        hw_en   = 1'b0;
        hw_addr = cur_reg;
        hw_data = e_reg;
        hr_en   = 1'b0;
        hr_addr = '0;
        iw_en   = 1'b0;
        iw_addr = id_idx(e_reg.owner);
        iw_data = {1'b1, cur_reg};
        ir_en   = 1'b0;
        ir_addr = id_idx(timer_id);

        case (state_reg)
            S_SWEEP:
            begin
                iw_en   = 1'b1;
                iw_addr = sw_reg;
                iw_data = '0;
                sw_next = sw_reg + ID_W'(1);
                if (sw_reg == ID_W'(ID_RANGE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    id_next    = timer_id;
                    exp_next   = now_ms + TIME_W'(timeout_ms);
                    now_next   = now_ms;
                    stat_next  = ST_OK;
                    pend_next  = 1'b0;
                    tick_next  = 1'b0;
                    k_next     = '0;
                    moved_next = 1'b0;
                    state_next = S_FIN;
                    case (cmd)
                        CMD_ADD, CMD_ADJUST:
                        begin
                            if (!id_ok)
                            begin
                                stat_next = ST_UNKNOWN;
                            end
                            else
                            begin
                                ir_en      = 1'b1;
                                state_next = S_IDCHK;
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RM_START;
                            end
                        end
                        CMD_TICK:
                        begin
                            tick_next  = 1'b1;
                            state_next = S_TK_RD;
                        end
                        CMD_CLEAR:
                        begin
                            clr_next = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_CL_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_IDCHK:
            begin
                e_next.expiry = exp_reg;
                e_next.owner  = id_reg;
                if (ird_q[SLOT_W])
                begin
                    cur_next   = ird_q[SLOT_W-1:0];
                    up_ok_next = (cmd_reg == CMD_ADD);
                    state_next = S_SD_START;
                end
                else if (cmd_reg == CMD_ADJUST)
                begin
                    stat_next  = ST_UNKNOWN;
                    state_next = S_FIN;
                end
                else if (count_reg >= CNT_W'(HEAP_SLOTS))
                begin
                    stat_next  = ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    cur_next   = count_reg[SLOT_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_SU_START;
                end
            end
            S_SD_START:
            begin
                child_next = c_w[SLOT_W-1:0];
                if (c_w < CH_W'(count_reg))
                begin
                    hr_en      = 1'b1;
                    hr_addr    = c_w[SLOT_W-1:0];
                    state_next = S_SD_R1;
                end
                else if (up_ok_reg && !moved_reg)
                begin
                    state_next = S_SU_START;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_SD_R1:
            begin
                left_next   = hrd_q;
                ch_next     = hrd_q;
                ch_idx_next = child_reg;
                if (c1_w < CH_W'(count_reg))
                begin
                    hr_en      = 1'b1;
                    hr_addr    = c1_w[SLOT_W-1:0];
                    state_next = S_SD_R2;
                end
                else
                begin
                    state_next = S_SD_CMP;
                end
            end
            S_SD_R2:
            begin
                // right child wins only when strictly earlier
                if (before_f(hrd_q.expiry, left_reg.expiry))
                begin
                    ch_next     = hrd_q;
                    ch_idx_next = c1_w[SLOT_W-1:0];
                end
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                if (before_f(e_reg.expiry, ch_reg.expiry))
                begin
                    state_next = (up_ok_reg && !moved_reg) ? S_SU_START : S_PLACE;
                end
                else
                begin
                    hw_en      = 1'b1;
                    hw_addr    = cur_reg;
                    hw_data    = ch_reg;
                    iw_en      = 1'b1;
                    iw_addr    = id_idx(ch_reg.owner);
                    iw_data    = {1'b1, cur_reg};
                    cur_next   = ch_idx_reg;
                    moved_next = 1'b1;
                    state_next = S_SD_START;
                end
            end
            S_SU_START:
            begin
                if (cur_reg == '0)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    hr_en      = 1'b1;
                    hr_addr    = (cur_reg - SLOT_W'(1)) >> 1;
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP:
            begin
                if (before_f(hrd_q.expiry, e_reg.expiry))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    hw_en      = 1'b1;
                    hw_addr    = cur_reg;
                    hw_data    = hrd_q;
                    iw_en      = 1'b1;
                    iw_addr    = id_idx(hrd_q.owner);
                    iw_data    = {1'b1, cur_reg};
                    cur_next   = (cur_reg - SLOT_W'(1)) >> 1;
                    state_next = S_SU_START;
                end
            end
            S_PLACE:
            begin
                hw_en      = 1'b1;
                hw_addr    = cur_reg;
                hw_data    = e_reg;
                iw_en      = 1'b1;
                iw_addr    = id_idx(e_reg.owner);
                iw_data    = {1'b1, cur_reg};
                state_next = tick_reg ? S_TK_RD : S_FIN;
            end
            S_RM_START:
            begin
                hr_en      = 1'b1;
                hr_addr    = '0;
                state_next = S_RM_ROOT;
            end
            S_RM_ROOT:
            begin
                iw_en      = 1'b1;
                iw_addr    = id_idx(hrd_q.owner);
                iw_data    = '0;
                count_next = count_reg - CNT_W'(1);
                cur_next   = '0;
                moved_next = 1'b0;
                up_ok_next = 1'b0;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = tick_reg ? S_TK_RD : S_FIN;
                end
                else
                begin
                    // last entry fills the hole at the root
                    hr_en      = 1'b1;
                    hr_addr    = SLOT_W'(count_reg - CNT_W'(1));
                    state_next = S_RM_LAST;
                end
            end
            S_RM_LAST:
            begin
                e_next     = hrd_q;
                state_next = S_SD_START;
            end
            S_TK_RD:
            begin
                hr_en      = 1'b1;
                hr_addr    = '0;
                state_next = S_TK_CHK;
            end
            S_TK_CHK:
            begin
                if (!root_fires)
                begin
                    state_next = S_FIN_W;
                end
                else if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        ov_next      = 1'b1;
                        o_exp_next   = 1'b1;
                        o_id_next    = pend_id_reg;
                        o_empty_next = 1'b0;
                        o_wait_next  = '0;
                        o_stat_next  = ST_OK;
                        o_last_next  = 1'b0;
                    end
                    pend_next    = 1'b1;
                    pend_id_next = hrd_q.owner;
                    k_next       = k_reg + KW'(1);
                    state_next   = S_RM_START;
                end
            end
            S_CL_RD:
            begin
                hr_en      = 1'b1;
                hr_addr    = clr_reg;
                state_next = S_CL_W;
            end
            S_CL_W:
            begin
                iw_en    = 1'b1;
                iw_addr  = id_idx(hrd_q.owner);
                iw_data  = '0;
                clr_next = clr_reg + SLOT_W'(1);
                if (CNT_W'(clr_reg) + CNT_W'(1) == count_reg)
                begin
                    count_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CL_RD;
                end
            end
            S_FIN:
            begin
                hr_en      = 1'b1;
                hr_addr    = '0;
                state_next = S_FIN_W;
            end
            S_FIN_W:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_exp_next   = pend_reg;
                    o_id_next    = pend_reg ? pend_id_reg : '0;
                    o_empty_next = (count_reg == '0);
                    o_wait_next  = wait_val;
                    o_stat_next  = stat_reg;
                    o_last_next  = 1'b1;
                    tick_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            count_reg <= '0;
            sw_reg    <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            tick_reg  <= 1'b0;
            k_reg     <= '0;
            moved_reg <= 1'b0;
            up_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sw_reg    <= sw_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
            tick_reg  <= tick_next;
            k_reg     <= k_next;
            moved_reg <= moved_next;
            up_ok_reg <= up_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        exp_reg     <= exp_next;
        now_reg     <= now_next;
        stat_reg    <= stat_next;
        cur_reg     <= cur_next;
        child_reg   <= child_next;
        e_reg       <= e_next;
        left_reg    <= left_next;
        ch_reg      <= ch_next;
        ch_idx_reg  <= ch_idx_next;
        pend_id_reg <= pend_id_next;
        clr_reg     <= clr_next;
        o_exp_reg   <= o_exp_next;
        o_id_reg    <= o_id_next;
        o_empty_reg <= o_empty_next;
        o_wait_reg  <= o_wait_next;
        o_stat_reg  <= o_stat_next;
        o_last_reg  <= o_last_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HEAP_SLOTS))
        else $error("entry count above heap size");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= KW'(MAX_RESULTS))
        else $error("too many timers fired in one tick");

    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && o_exp_reg |-> o_stat_reg == ST_OK)
        else $error("fired timer with error status");

    a_empty_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && o_last_reg && o_empty_reg |-> o_wait_reg == '0)
        else $error("wait reported on empty queue");
`endif

endmodule
`default_nettype wire
